// ===== hdl/rdwgs_pkg.sv =====
`default_nettype none

package rdwgs_pkg;

   // Channel payloads
   typedef struct packed {
      logic signed [19:0] rd_x;
      logic        [19:0] rd_y;
   } req_type;

   typedef struct packed {
      logic [25:0] lat_microdeg;
      logic [22:0] lon_microdeg;
   } rsp_type;

   // Pipeline depth, from input register to output register
   localparam int NumStages = 13;

   // Grid origin and offset limit, in metres
   localparam logic signed [21:0] OrgRdX   = 22'sd155000;
   localparam logic signed [21:0] OrgRdY   = 22'sd463000;
   localparam logic signed [21:0] OffLimit = 22'sd199999;

   // Metres to Q2.30: q = m * 10737 + floor((m * 1307 + 1562) / 3125)
   localparam logic [31:0] Q30Whole       = 32'd10737;
   localparam logic [27:0] Q30Frac        = 28'd1307;
   localparam logic [27:0] Q30Half        = 28'd1562;
   localparam logic [56:0] Recip3125      = 57'd351843721;
   localparam int          Recip3125Shift = 40;

   // Arcseconds (Q18) to microdegrees: floor((s * 2500 + 4.5 * 2^18) / 2^18 / 9)
   localparam logic signed [43:0] AsecScale  = 44'sd2500;
   localparam logic signed [43:0] AsecHalf   = 44'sd1179648;
   localparam int                 AsecShift  = 18;
   localparam logic signed [29:0] Div9Bias   = 30'sd301989888;
   localparam logic signed [26:0] Div9Offset = 27'sd33554432;
   localparam logic        [57:0] Recip9     = 58'd477218589;
   localparam int                 Recip9Shift = 32;

   // WGS84 origin and output ranges, in microdegrees
   localparam logic signed [27:0] LatOrigin = 28'sd52155170;
   localparam logic signed [27:0] LatLow    = 28'sd50000000;
   localparam logic signed [27:0] LatHigh   = 28'sd54000000;
   localparam logic signed [27:0] LonOrigin = 28'sd5387206;
   localparam logic signed [27:0] LonLow    = 28'sd2000000;
   localparam logic signed [27:0] LonHigh   = 28'sd8000000;

   // Q30 monomials and Q18 terms
   typedef logic signed [35:0] mono_type;
   typedef logic signed [37:0] part_type;

   localparam int NumNorth = 11;
   localparam int NumEast  = 12;
   localparam int NumParts = 3;

   // North series, Q14.18 arcseconds, in order:
   // y, x2, y2, x2y, y3, x2y2, x, x4, x2y3, x4y, xy
   localparam mono_type NorthCoef [NumNorth] = '{
      36'sd848207252, -36'sd8541430, -36'sd64881, -36'sd222765, -36'sd17170,
      -36'sd4480, -36'sd1935, 36'sd1389, -36'sd102, 36'sd87, -36'sd31};

   // East series, in order:
   // x, xy, xy2, x3, xy3, x3y, y, x3y2, xy4, y2, x2, x5
   localparam mono_type EastCoef [NumEast] = '{
      36'sd1379016156, 36'sd27773328, 36'sd643972, -36'sd214657, 36'sd14664,
      -36'sd14698, 36'sd3143, -36'sd671, 36'sd336, 36'sd58, -36'sd58, 36'sd68};

   typedef struct packed {
      logic        neg;
      logic [17:0] mag;
   } axis_off_type;

   typedef struct packed {
      logic        neg;
      logic [31:0] whole;
      logic [27:0] frac;
   } axis_split_type;

   typedef struct packed {
      logic        neg;
      logic [31:0] whole;
      logic [16:0] quot;
   } axis_quot_type;

   typedef struct packed {
      mono_type x;
      mono_type y;
      mono_type x2;
      mono_type x3;
      mono_type x4;
      mono_type x5;
      mono_type y2;
      mono_type y3;
      mono_type y4;
      mono_type xy;
      mono_type x2y;
      mono_type x2y2;
      mono_type x2y3;
      mono_type x4y;
      mono_type xy2;
      mono_type xy3;
      mono_type x3y;
      mono_type x3y2;
      mono_type xy4;
   } mono_set_type;

   // Clamp a metre offset and split it into sign and magnitude
   function automatic axis_off_type clamp_offset(input logic signed [21:0] off);
      logic signed [21:0] lim;
      logic signed [21:0] abs_val;
      axis_off_type       res;
      lim = off;
      if (lim > OffLimit) begin
         lim = OffLimit;
      end else if (lim < -OffLimit) begin
         lim = -OffLimit;
      end
      abs_val = lim[21] ? -lim : lim;
      res.neg = lim[21];
      res.mag = abs_val[17:0];
      return res;
   endfunction

   // Whole part of the Q30 scale and the numerator of its remainder
   function automatic axis_split_type split_q30(input axis_off_type a);
      axis_split_type res;
      res.neg   = a.neg;
      res.whole = 32'(a.mag) * Q30Whole;
      res.frac  = 28'(a.mag) * Q30Frac + Q30Half;
      return res;
   endfunction

   // Divide the remainder numerator by 3125 through a reciprocal
   function automatic axis_quot_type quot_q30(input axis_split_type a);
      logic [56:0]   prod;
      axis_quot_type res;
      prod      = 57'(a.frac) * Recip3125;
      res.neg   = a.neg;
      res.whole = a.whole;
      res.quot  = 17'(prod >> Recip3125Shift);
      return res;
   endfunction

   // Join the parts and restore the sign
   function automatic mono_type join_q30(input axis_quot_type a);
      logic [31:0] q;
      mono_type    m;
      q = a.whole + 32'(a.quot);
      m = $signed(36'(q));
      return a.neg ? -m : m;
   endfunction

   // (a * b) >> 30, rounded to nearest, ties away from zero; the magnitude
   // product and its rounding wrap at 64 bits
   function automatic mono_type mul_q30(input mono_type a, input mono_type b);
      logic [35:0] mag_a;
      logic [35:0] mag_b;
      logic [63:0] prod;
      logic [63:0] rnd;
      mono_type    res;
      mag_a = a[35] ? 36'(-a) : 36'(a);
      mag_b = b[35] ? 36'(-b) : 36'(b);
      prod  = 64'(mag_a) * 64'(mag_b);
      rnd   = (prod + (64'd1 << 29)) >> 30;
      res   = $signed(rnd[35:0]);
      return (a[35] ^ b[35]) ? -res : res;
   endfunction

   function automatic part_type sum4(input mono_type a, input mono_type b,
                                     input mono_type c, input mono_type d);
      return 38'(a) + 38'(b) + 38'(c) + 38'(d);
   endfunction

   // Add three partial sums and saturate to Q14.18
   function automatic logic signed [31:0] sat32(input part_type a, input part_type b,
                                                input part_type c);
      logic signed [39:0] tot;
      tot = 40'(a) + 40'(b) + 40'(c);
      if (tot > 40'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (tot < -40'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return tot[31:0];
      end
   endfunction

   // Scale arcseconds to a microdegree numerator over 9, biased to stay positive
   function automatic logic [28:0] bias_asec(input logic signed [31:0] s);
      logic signed [43:0] n;
      logic signed [25:0] w;
      logic signed [29:0] u;
      n = 44'(s) * AsecScale + AsecHalf;
      w = 26'(n >>> AsecShift);
      u = 30'(w) + Div9Bias;
      return u[28:0];
   endfunction

   // Divide by 9 through a reciprocal and remove the bias
   function automatic logic signed [26:0] div9_inc(input logic [28:0] u);
      logic [57:0] prod;
      logic [25:0] quot;
      prod = 58'(u) * Recip9;
      quot = 26'(prod >> Recip9Shift);
      return $signed({1'b0, quot}) - Div9Offset;
   endfunction

   function automatic logic [25:0] clamp_udeg(input logic signed [26:0] inc,
                                              input logic signed [27:0] origin,
                                              input logic signed [27:0] lo,
                                              input logic signed [27:0] hi);
      logic signed [27:0] v;
      v = 28'(inc) + origin;
      if (v < lo) begin
         v = lo;
      end else if (v > hi) begin
         v = hi;
      end
      return v[25:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rd_to_wgs84_converter_core.sv =====
// RD grid to WGS84 converter.
// The request channel (req_valid, req_stall, req_data) carries one RD coordinate
// pair in whole metres; the response channel (rsp_valid, rsp_stall, rsp_data)
// returns latitude and longitude in whole microdegrees, one response per
// request, in request order. Each side transfers at a clock edge where valid
// is high and stall is low.
// While the response side does not stall, a new pair can enter every cycle,
// so the sustained rate is one pair per clock. A request passes through 13
// register stages (four for offset and scaling to Q2.30, three rounds of
// monomial products, coefficient terms, two adder levels, arcsecond scaling,
// divide by nine, clamp) before its response is valid.
// Each stage holds its own valid bit and moves forward when the stage ahead is
// empty or moving, so empty slots close up while the response side stalls and
// requests keep being taken until every stage is full. req_stall is high only
// then. A stalled response holds its value until it transfers.
// Synchronous reset empties all stages; no response is pending afterwards.
`default_nettype none

module rd_to_wgs84_converter_core
   import rdwgs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;
   logic [NumStages-1:0] vld_prev;
   logic [NumStages-1:0] stage_en;

   axis_off_type   s1_x_in, s1_y_in, s1_x_ff, s1_y_ff;
   axis_split_type s2_x_in, s2_y_in, s2_x_ff, s2_y_ff;
   axis_quot_type  s3_x_in, s3_y_in, s3_x_ff, s3_y_ff;
   mono_type       s4_x_in, s4_y_in, s4_x_ff, s4_y_ff;
   mono_set_type   s5_in, s5_ff, s6_in, s6_ff, s7_in, s7_ff;

   mono_type north_term_in [NumNorth];
   mono_type north_term_ff [NumNorth];
   mono_type east_term_in  [NumEast];
   mono_type east_term_ff  [NumEast];
   part_type north_part_in [NumParts];
   part_type north_part_ff [NumParts];
   part_type east_part_in  [NumParts];
   part_type east_part_ff  [NumParts];

   logic signed [31:0] sum_n_in, sum_n_ff, sum_e_in, sum_e_ff;
   logic [28:0]        bias_n_in, bias_n_ff, bias_e_in, bias_e_ff;
   logic signed [26:0] inc_n_in, inc_n_ff, inc_e_in, inc_e_ff;
   logic [25:0]        lat_wide, lon_wide;
   rsp_type            rsp_data_in, rsp_data_ff;

   // Advance a stage when it is empty or the stage ahead advances
   assign stage_en[NumStages-1] = !vld_ff[NumStages-1] || !rsp_stall;

   for (genvar g = 0; g < NumStages - 1; g++) begin : g_en
      assign stage_en[g] = !vld_ff[g] || stage_en[g+1];
   end

   assign vld_prev = {vld_ff[NumStages-2:0], req_valid};
   assign vld_in   = (stage_en & vld_prev) | (~stage_en & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = vld_ff[NumStages-1];
   assign rsp_data  = rsp_data_ff;

   // Stage 1: offset by the grid origin and clamp
   always_comb begin
      s1_x_in = clamp_offset(22'(req_data.rd_x) - OrgRdX);
      s1_y_in = clamp_offset($signed({2'b00, req_data.rd_y}) - OrgRdY);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_x_ff <= s1_x_in;
         s1_y_ff <= s1_y_in;
      end
   end

   // Stage 2: whole part and remainder numerator of the Q30 scale
   always_comb begin
      s2_x_in = split_q30(s1_x_ff);
      s2_y_in = split_q30(s1_y_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_x_ff <= s2_x_in;
         s2_y_ff <= s2_y_in;
      end
   end

   // Stage 3: remainder divided by 3125
   always_comb begin
      s3_x_in = quot_q30(s2_x_ff);
      s3_y_in = quot_q30(s2_y_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_x_ff <= s3_x_in;
         s3_y_ff <= s3_y_in;
      end
   end

   // Stage 4: signed dX and dY in Q2.30
   always_comb begin
      s4_x_in = join_q30(s3_x_ff);
      s4_y_in = join_q30(s3_y_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_x_ff <= s4_x_in;
         s4_y_ff <= s4_y_in;
      end
   end

   // Stage 5: second-order monomials
   always_comb begin
      s5_in    = '0;
      s5_in.x  = s4_x_ff;
      s5_in.y  = s4_y_ff;
      s5_in.x2 = mul_q30(s4_x_ff, s4_x_ff);
      s5_in.y2 = mul_q30(s4_y_ff, s4_y_ff);
      s5_in.xy = mul_q30(s4_x_ff, s4_y_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_ff <= s5_in;
      end
   end

   // Stage 6: third- and fourth-order monomials from the second-order ones
   always_comb begin
      s6_in      = s5_ff;
      s6_in.x3   = mul_q30(s5_ff.x2, s5_ff.x);
      s6_in.x4   = mul_q30(s5_ff.x2, s5_ff.x2);
      s6_in.y3   = mul_q30(s5_ff.y2, s5_ff.y);
      s6_in.y4   = mul_q30(s5_ff.y2, s5_ff.y2);
      s6_in.x2y  = mul_q30(s5_ff.x2, s5_ff.y);
      s6_in.x2y2 = mul_q30(s5_ff.x2, s5_ff.y2);
      s6_in.xy2  = mul_q30(s5_ff.x, s5_ff.y2);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s6_ff <= s6_in;
      end
   end

   // Stage 7: remaining higher-order monomials
   always_comb begin
      s7_in      = s6_ff;
      s7_in.x5   = mul_q30(s6_ff.x4, s6_ff.x);
      s7_in.x2y3 = mul_q30(s6_ff.x2, s6_ff.y3);
      s7_in.x4y  = mul_q30(s6_ff.x4, s6_ff.y);
      s7_in.xy3  = mul_q30(s6_ff.x, s6_ff.y3);
      s7_in.x3y  = mul_q30(s6_ff.x3, s6_ff.y);
      s7_in.x3y2 = mul_q30(s6_ff.x3, s6_ff.y2);
      s7_in.xy4  = mul_q30(s6_ff.x, s6_ff.y4);
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s7_ff <= s7_in;
      end
   end

   // Stage 8: coefficient times monomial, back to Q18
   always_comb begin
      north_term_in[0]  = mul_q30(NorthCoef[0],  s7_ff.y);
      north_term_in[1]  = mul_q30(NorthCoef[1],  s7_ff.x2);
      north_term_in[2]  = mul_q30(NorthCoef[2],  s7_ff.y2);
      north_term_in[3]  = mul_q30(NorthCoef[3],  s7_ff.x2y);
      north_term_in[4]  = mul_q30(NorthCoef[4],  s7_ff.y3);
      north_term_in[5]  = mul_q30(NorthCoef[5],  s7_ff.x2y2);
      north_term_in[6]  = mul_q30(NorthCoef[6],  s7_ff.x);
      north_term_in[7]  = mul_q30(NorthCoef[7],  s7_ff.x4);
      north_term_in[8]  = mul_q30(NorthCoef[8],  s7_ff.x2y3);
      north_term_in[9]  = mul_q30(NorthCoef[9],  s7_ff.x4y);
      north_term_in[10] = mul_q30(NorthCoef[10], s7_ff.xy);

      east_term_in[0]  = mul_q30(EastCoef[0],  s7_ff.x);
      east_term_in[1]  = mul_q30(EastCoef[1],  s7_ff.xy);
      east_term_in[2]  = mul_q30(EastCoef[2],  s7_ff.xy2);
      east_term_in[3]  = mul_q30(EastCoef[3],  s7_ff.x3);
      east_term_in[4]  = mul_q30(EastCoef[4],  s7_ff.xy3);
      east_term_in[5]  = mul_q30(EastCoef[5],  s7_ff.x3y);
      east_term_in[6]  = mul_q30(EastCoef[6],  s7_ff.y);
      east_term_in[7]  = mul_q30(EastCoef[7],  s7_ff.x3y2);
      east_term_in[8]  = mul_q30(EastCoef[8],  s7_ff.xy4);
      east_term_in[9]  = mul_q30(EastCoef[9],  s7_ff.y2);
      east_term_in[10] = mul_q30(EastCoef[10], s7_ff.x2);
      east_term_in[11] = mul_q30(EastCoef[11], s7_ff.x5);
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         north_term_ff <= north_term_in;
         east_term_ff  <= east_term_in;
      end
   end

   // Stage 9: partial sums over groups of four terms
   always_comb begin
      north_part_in[0] = sum4(north_term_ff[0], north_term_ff[1],
                              north_term_ff[2], north_term_ff[3]);
      north_part_in[1] = sum4(north_term_ff[4], north_term_ff[5],
                              north_term_ff[6], north_term_ff[7]);
      north_part_in[2] = sum4(north_term_ff[8], north_term_ff[9],
                              north_term_ff[10], '0);
      east_part_in[0]  = sum4(east_term_ff[0], east_term_ff[1],
                              east_term_ff[2], east_term_ff[3]);
      east_part_in[1]  = sum4(east_term_ff[4], east_term_ff[5],
                              east_term_ff[6], east_term_ff[7]);
      east_part_in[2]  = sum4(east_term_ff[8], east_term_ff[9],
                              east_term_ff[10], east_term_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         north_part_ff <= north_part_in;
         east_part_ff  <= east_part_in;
      end
   end

   // Stage 10: final sums, saturated to Q14.18
   always_comb begin
      sum_n_in = sat32(north_part_ff[0], north_part_ff[1], north_part_ff[2]);
      sum_e_in = sat32(east_part_ff[0], east_part_ff[1], east_part_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         sum_n_ff <= sum_n_in;
         sum_e_ff <= sum_e_in;
      end
   end

   // Stage 11: arcseconds to a biased microdegree numerator
   always_comb begin
      bias_n_in = bias_asec(sum_n_ff);
      bias_e_in = bias_asec(sum_e_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[10]) begin
         bias_n_ff <= bias_n_in;
         bias_e_ff <= bias_e_in;
      end
   end

   // Stage 12: floor divide by nine
   always_comb begin
      inc_n_in = div9_inc(bias_n_ff);
      inc_e_in = div9_inc(bias_e_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[11]) begin
         inc_n_ff <= inc_n_in;
         inc_e_ff <= inc_e_in;
      end
   end

   // Stage 13: add the WGS84 origin and clamp to the output ranges
   always_comb begin
      lat_wide = clamp_udeg(inc_n_ff, LatOrigin, LatLow, LatHigh);
      lon_wide = clamp_udeg(inc_e_ff, LonOrigin, LonLow, LonHigh);
      rsp_data_in.lat_microdeg = lat_wide;
      rsp_data_in.lon_microdeg = lon_wide[22:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[12]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rdwgs_checker.sv =====
`default_nettype none

module rdwgs_checker
   import rdwgs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // Reset leaves no response pending
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With the output stage empty the pipeline always has room
   a_room_when_empty : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !rsp_valid) |-> !req_stall)
      else $error("request stalled while output stage empty");

   // Latitude stays inside its clamp range
   a_lat_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (28'(rsp_data.lat_microdeg) >= 28'(LatLow)) &&
                    (28'(rsp_data.lat_microdeg) <= 28'(LatHigh)))
      else $error("latitude out of range");

   // Longitude stays inside its clamp range
   a_lon_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (28'(rsp_data.lon_microdeg) >= 28'(LonLow)) &&
                    (28'(rsp_data.lon_microdeg) <= 28'(LonHigh)))
      else $error("longitude out of range");

   // A stalled response holds until it transfers
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response dropped or changed");

endmodule

bind rd_to_wgs84_converter_core rdwgs_checker u_rdwgs_checker (.*);

`default_nettype wire

// ===== verif/rd_to_wgs84_checker.sv =====
module rd_to_wgs84_checker
   import rdwgs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           mismatches,
   output int           outstanding
);

   // Grid origin, clamp limit and output ranges
   localparam longint GridX     = 155000;
   localparam longint GridY     = 463000;
   localparam longint OffsetCap = 199999;
   localparam longint LatBase   = 52155170;
   localparam longint LatMin    = 50000000;
   localparam longint LatMax    = 54000000;
   localparam longint LonBase   = 5387206;
   localparam longint LonMin    = 2000000;
   localparam longint LonMax    = 8000000;
   // 3600 s/deg over 1e6 udeg/deg, at Q18: 9 * 2^18 per 2500
   localparam longint ArcDen    = 9 * 262144;

   rsp_type fix_queue[$];
   int      error_count = 0;

   // Metre offset to Q2.30, clamped, rounded to nearest with ties away from zero
   function automatic longint metres_to_q30(input longint off);
      longint          lim;
      longint unsigned mag;
      longint unsigned q;
      lim = off;
      if (lim > OffsetCap) begin
         lim = OffsetCap;
      end else if (lim < -OffsetCap) begin
         lim = -OffsetCap;
      end
      mag = (lim < 0) ? -lim : lim;
      q   = ((mag << 30) + 50000) / 100000;
      return (lim < 0) ? -longint'(q) : longint'(q);
   endfunction

   // (a * b) >> 30 on magnitudes; the magnitude product wraps at 64 bits
   function automatic longint q30_product(input longint a, input longint b);
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned p;
      longint unsigned r;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p  = ma * mb;
      r  = (p + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Q18 arcseconds to microdegrees, rounded half up, added to origin and clamped
   function automatic longint arcsec_to_udeg(input longint sum, input longint origin,
                                             input longint lo, input longint hi);
      longint n;
      longint inc;
      longint v;
      n   = sum * 2500 + ArcDen / 2;
      inc = (n >= 0) ? n / ArcDen : -((-n + ArcDen - 1) / ArcDen);
      v   = origin + inc;
      if (v < lo) begin
         v = lo;
      end
      if (v > hi) begin
         v = hi;
      end
      return v;
   endfunction

   // Expected latitude and longitude for one grid pair
   function automatic rsp_type predict_fix(input req_type pair);
      longint  x, y, x2, x3, x4, x5, y2, y3, y4, xy, x2y, x2y2, x2y3, x4y;
      longint  xy2, xy3, x3y, x3y2, xy4;
      longint  north;
      longint  east;
      rsp_type fix;
      x    = metres_to_q30(longint'($signed(pair.rd_x)) - GridX);
      y    = metres_to_q30(longint'(pair.rd_y) - GridY);
      x2   = q30_product(x, x);
      x3   = q30_product(x2, x);
      x4   = q30_product(x2, x2);
      x5   = q30_product(x4, x);
      y2   = q30_product(y, y);
      y3   = q30_product(y2, y);
      y4   = q30_product(y2, y2);
      xy   = q30_product(x, y);
      x2y  = q30_product(x2, y);
      x2y2 = q30_product(x2, y2);
      x2y3 = q30_product(x2, y3);
      x4y  = q30_product(x4, y);
      xy2  = q30_product(x, y2);
      xy3  = q30_product(x, y3);
      x3y  = q30_product(x3, y);
      x3y2 = q30_product(x3, y2);
      xy4  = q30_product(x, y4);

      north = q30_product(848207252, y) + q30_product(-8541430, x2)
            + q30_product(-64881, y2) + q30_product(-222765, x2y)
            + q30_product(-17170, y3) + q30_product(-4480, x2y2)
            + q30_product(-1935, x) + q30_product(1389, x4)
            + q30_product(-102, x2y3) + q30_product(87, x4y)
            + q30_product(-31, xy);
      east  = q30_product(1379016156, x) + q30_product(27773328, xy)
            + q30_product(643972, xy2) + q30_product(-214657, x3)
            + q30_product(14664, xy3) + q30_product(-14698, x3y)
            + q30_product(3143, y) + q30_product(-671, x3y2)
            + q30_product(336, xy4) + q30_product(58, y2)
            + q30_product(-58, x2) + q30_product(68, x5);

      fix.lat_microdeg = 26'(arcsec_to_udeg(clip32(north), LatBase, LatMin, LatMax));
      fix.lon_microdeg = 23'(arcsec_to_udeg(clip32(east), LonBase, LonMin, LonMax));
      return fix;
   endfunction

   // Compare each response transfer with the oldest prediction, then queue new ones
   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (fix_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: response with none pending: lat %0d lon %0d",
                           $time, rsp_data.lat_microdeg, rsp_data.lon_microdeg);
               end
            end else begin
               want = fix_queue.pop_front();
               if (rsp_data.lat_microdeg !== want.lat_microdeg ||
                   rsp_data.lon_microdeg !== want.lon_microdeg) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: expected lat %0d lon %0d, got lat %0d lon %0d",
                              $time, want.lat_microdeg, want.lon_microdeg,
                              rsp_data.lat_microdeg, rsp_data.lon_microdeg);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            fix_queue.push_back(predict_fix(req_data));
         end
      end
      mismatches  <= error_count;
      outstanding <= fix_queue.size();
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import rdwgs_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;
   bit      calm      = 1'b0;
   bit      hold_ask  = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rd_to_wgs84_converter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rd_to_wgs84_checker fix_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   function automatic req_type pair_of(input int east_m, input int north_m);
      req_type pair;
      pair.rd_x = 20'(east_m);
      pair.rd_y = 20'(north_m);
      return pair;
   endfunction

   // Mostly in-range pairs, some near the offset clamp, some raw field noise
   function automatic req_type random_pair();
      int      kind;
      int      dx;
      int      dy;
      req_type pair;
      kind = $urandom_range(99);
      if (kind < 70) begin
         pair = pair_of(int'($urandom_range(307000)) - 7000,
                        289000 + int'($urandom_range(340000)));
      end else if (kind < 85) begin
         dx = 180000 + int'($urandom_range(50000));
         dy = 180000 + int'($urandom_range(50000));
         if ($urandom_range(1)) begin
            dx = -dx;
         end
         if ($urandom_range(1)) begin
            dy = -dy;
         end
         pair = pair_of(155000 + dx, 463000 + dy);
      end else begin
         pair = req_type'(40'({$urandom, $urandom}));
      end
      return pair;
   endfunction

   // Offer one pair, idling at random first, and hold it until it transfers
   task automatic send_pair(input req_type pair);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         req_data  <= req_type'(40'({$urandom, $urandom}));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pair;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted response has transferred
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // Response side: random stall, a long hold-off on request, none while calm
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_ask) begin
            hold_ask  = 1'b0;
            hold_left = 79;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 21);
         end
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Grid origin and corners of the nominal range
      send_pair(pair_of(155000, 463000));
      send_pair(pair_of(-7000, 289000));
      send_pair(pair_of(300000, 629000));
      send_pair(pair_of(-7000, 629000));
      send_pair(pair_of(300000, 289000));
      // Field extremes; these drive the offsets into their clamp and the east sum into saturation
      send_pair(pair_of(-524288, 0));
      send_pair(pair_of(524287, 1048575));
      send_pair(pair_of(0, 0));
      send_pair(pair_of(-1, 1048575));
      send_pair(pair_of(524287, 0));
      send_pair(pair_of(-524288, 1048575));
      // Just inside and just past the offset clamp on both axes
      send_pair(pair_of(354999, 662999));
      send_pair(pair_of(355000, 663000));
      send_pair(pair_of(-44999, 263001));
      send_pair(pair_of(-45000, 263000));
      // One axis at its clamp, the other at the origin
      send_pair(pair_of(155000, 0));
      send_pair(pair_of(354999, 463000));
      send_pair(pair_of(-44999, 463000));
      send_pair(pair_of(155000, 662999));
      // Alternating bit patterns
      send_pair(pair_of(32'h55555, 32'haaaaa));
      send_pair(pair_of(32'haaaaa, 32'h55555));

      for (int n = 0; n < 1400; n++) begin
         if (n == 300) begin
            hold_ask = 1'b1;
         end
         if (n == 700) begin
            drain();
         end
         calm = (n >= 900 && n < 1100);
         send_pair(random_pair());
      end
      calm = 1'b0;

      drain();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Guard against a hang
   initial begin
      #2000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rdwgs_pkg.sv
hdl/rd_to_wgs84_converter_core.sv
hdl/rdwgs_checker.sv
verif/rd_to_wgs84_checker.sv
verif/testbench.sv
